@@ sv/rtpq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Release-time priority queue: shared package
// Types, codes and defaults used by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package rtpq_pkg;

  // Default number of job slots
  localparam int unsigned DepthDefault = 16;

  // Field widths fixed by the item format
  localparam int unsigned JobW   = 16;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned PrioW  = 4;
  localparam int unsigned ProgW  = 2;
  localparam int unsigned StatW  = 2;

  // Operation codes of an input item
  typedef enum logic {
    OpInsert  = 1'b0,
    OpRelease = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    StAccepted = 2'd0,
    StFull     = 2'd1,
    StReleased = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    SIdle,
    SInsert,
    SRelease
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the input item
    logic insert;  // place the captured job in the row
    logic pop;     // emit the head job and shift the row down
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic head_due;  // head slot holds a job due at the captured time
    logic next_due;  // second slot holds a job due as well
  } stat_t;

endpackage

@@ sv/rtpq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Release-time priority queue: controller
// Sequences one item at a time: a single insert step, or one pop per due job.
// ----------------------------------------------------------------------------
module rtpq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  rtpq_pkg::op_e   op_i,
  input  rtpq_pkg::stat_t stat_i,
  output logic            busy,
  output rtpq_pkg::cmd_t  cmd_o
);

  rtpq_pkg::state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtpq_pkg::SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Choose the next state and issue commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      rtpq_pkg::SIdle: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = (op_i == rtpq_pkg::OpInsert) ? rtpq_pkg::SInsert
                                                    : rtpq_pkg::SRelease;
        end
      end
      rtpq_pkg::SInsert: begin
        cmd_o.insert = 1'b1;
        state_d      = rtpq_pkg::SIdle;
      end
      rtpq_pkg::SRelease: begin
        // Pop while the head is due; finish once the next one is not
        if (stat_i.head_due) begin
          cmd_o.pop = 1'b1;
          if (!stat_i.next_due) begin
            state_d = rtpq_pkg::SIdle;
          end
        end else begin
          state_d = rtpq_pkg::SIdle;
        end
      end
      default: begin
        state_d = rtpq_pkg::SIdle;
      end
    endcase
  end

endmodule

@@ sv/rtpq_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Release-time priority queue: datapath
// Sorted row of job slots with a compare per slot, the fill count and the
// result register.
// ----------------------------------------------------------------------------
module rtpq_dp #(
  parameter int unsigned Depth = rtpq_pkg::DepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rtpq_pkg::cmd_t              cmd_i,
  output rtpq_pkg::stat_t             stat_o,
  input  logic [rtpq_pkg::JobW-1:0]   job_id_i,
  input  logic [rtpq_pkg::TimeW-1:0]  start_time_i,
  input  logic [rtpq_pkg::PrioW-1:0]  priority_req_i,
  input  logic [rtpq_pkg::ProgW-1:0]  program_req_i,
  input  logic [rtpq_pkg::TimeW-1:0]  elapsed_time_i,
  output logic                        strobe_o,
  output logic [rtpq_pkg::StatW-1:0]  status_o,
  output logic [rtpq_pkg::JobW-1:0]   out_job_id_o,
  output logic [rtpq_pkg::PrioW-1:0]  out_priority_o,
  output logic [rtpq_pkg::ProgW-1:0]  out_program_o,
  output logic [rtpq_pkg::TimeW-1:0]  out_start_time_o,
  output logic                        last_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  // Captured item
  logic [rtpq_pkg::JobW-1:0]  job_q;
  logic [rtpq_pkg::TimeW-1:0] start_q;
  logic [rtpq_pkg::PrioW-1:0] prio_q;
  logic [rtpq_pkg::ProgW-1:0] prog_q;
  logic [rtpq_pkg::TimeW-1:0] now_q;

  // Slot row, slot 0 is the head
  logic [rtpq_pkg::TimeW-1:0] slot_start_q [Depth];
  logic [rtpq_pkg::PrioW-1:0] slot_prio_q  [Depth];
  logic [rtpq_pkg::JobW-1:0]  slot_job_q   [Depth];
  logic [rtpq_pkg::ProgW-1:0] slot_prog_q  [Depth];
  logic [rtpq_pkg::TimeW-1:0] slot_start_d [Depth];
  logic [rtpq_pkg::PrioW-1:0] slot_prio_d  [Depth];
  logic [rtpq_pkg::JobW-1:0]  slot_job_d   [Depth];
  logic [rtpq_pkg::ProgW-1:0] slot_prog_d  [Depth];

  logic [CntW-1:0] fill_q, fill_d;

  logic             full;
  logic             do_insert;
  logic [Depth-1:0] after;       // slot sorts at or before the new job
  logic [Depth-1:0] prev_after;  // same flag for the slot above

  // Result register
  logic                       strobe_q, strobe_d;
  logic [rtpq_pkg::StatW-1:0] status_q, status_d;
  logic [rtpq_pkg::JobW-1:0]  res_job_q, res_job_d;
  logic [rtpq_pkg::PrioW-1:0] res_prio_q, res_prio_d;
  logic [rtpq_pkg::ProgW-1:0] res_prog_q, res_prog_d;
  logic [rtpq_pkg::TimeW-1:0] res_start_q, res_start_d;
  logic                       last_q, last_d;

  assign full      = (fill_q == CntW'(Depth));
  assign do_insert = cmd_i.insert && !full;

  // Compare every occupied slot with the new job
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      after[i] = (CntW'(i) < fill_q) &&
                 ((slot_start_q[i] < start_q) ||
                  ((slot_start_q[i] == start_q) && (slot_prio_q[i] <= prio_q)));
    end
  end

  assign prev_after = {after[Depth-2:0], 1'b1};

  // Due flags for the head and the slot behind it
  assign stat_o.head_due = (fill_q != '0) && (slot_start_q[0] <= now_q);
  assign stat_o.next_due = (fill_q > CntW'(1)) && (slot_start_q[1] <= now_q);

  // Per slot: keep, take the new job, shift up on insert, shift down on pop
  for (genvar g = 0; g < Depth; g++) begin : g_slot
    logic [rtpq_pkg::TimeW-1:0] up_start, dn_start;
    logic [rtpq_pkg::PrioW-1:0] up_prio, dn_prio;
    logic [rtpq_pkg::JobW-1:0]  up_job, dn_job;
    logic [rtpq_pkg::ProgW-1:0] up_prog, dn_prog;

    if (g == 0) begin : g_head
      assign up_start = start_q;
      assign up_prio  = prio_q;
      assign up_job   = job_q;
      assign up_prog  = prog_q;
    end else begin : g_body
      assign up_start = slot_start_q[g-1];
      assign up_prio  = slot_prio_q[g-1];
      assign up_job   = slot_job_q[g-1];
      assign up_prog  = slot_prog_q[g-1];
    end

    if (g == Depth - 1) begin : g_tail
      assign dn_start = slot_start_q[g];
      assign dn_prio  = slot_prio_q[g];
      assign dn_job   = slot_job_q[g];
      assign dn_prog  = slot_prog_q[g];
    end else begin : g_inner
      assign dn_start = slot_start_q[g+1];
      assign dn_prio  = slot_prio_q[g+1];
      assign dn_job   = slot_job_q[g+1];
      assign dn_prog  = slot_prog_q[g+1];
    end

    always_comb begin
      slot_start_d[g] = slot_start_q[g];
      slot_prio_d[g]  = slot_prio_q[g];
      slot_job_d[g]   = slot_job_q[g];
      slot_prog_d[g]  = slot_prog_q[g];
      if (do_insert && !after[g]) begin
        if (prev_after[g]) begin
          slot_start_d[g] = start_q;
          slot_prio_d[g]  = prio_q;
          slot_job_d[g]   = job_q;
          slot_prog_d[g]  = prog_q;
        end else begin
          slot_start_d[g] = up_start;
          slot_prio_d[g]  = up_prio;
          slot_job_d[g]   = up_job;
          slot_prog_d[g]  = up_prog;
        end
      end else if (cmd_i.pop) begin
        slot_start_d[g] = dn_start;
        slot_prio_d[g]  = dn_prio;
        slot_job_d[g]   = dn_job;
        slot_prog_d[g]  = dn_prog;
      end
    end
  end

  // Advance the fill count and form the result
  always_comb begin
    fill_d      = fill_q;
    strobe_d    = 1'b0;
    status_d    = rtpq_pkg::StAccepted;
    res_job_d   = '0;
    res_prio_d  = '0;
    res_prog_d  = '0;
    res_start_d = '0;
    last_d      = 1'b1;
    if (cmd_i.insert) begin
      strobe_d = 1'b1;
      if (full) begin
        status_d = rtpq_pkg::StFull;
      end else begin
        fill_d = fill_q + CntW'(1);
      end
    end else if (cmd_i.pop) begin
      fill_d      = fill_q - CntW'(1);
      strobe_d    = 1'b1;
      status_d    = rtpq_pkg::StReleased;
      res_job_d   = slot_job_q[0];
      res_prio_d  = slot_prio_q[0];
      res_prog_d  = slot_prog_q[0];
      res_start_d = slot_start_q[0];
      last_d      = !stat_o.next_due;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      strobe_q <= strobe_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      job_q   <= job_id_i;
      start_q <= start_time_i;
      prio_q  <= priority_req_i;
      prog_q  <= program_req_i;
      now_q   <= elapsed_time_i;
    end
    for (int i = 0; i < Depth; i++) begin
      slot_start_q[i] <= slot_start_d[i];
      slot_prio_q[i]  <= slot_prio_d[i];
      slot_job_q[i]   <= slot_job_d[i];
      slot_prog_q[i]  <= slot_prog_d[i];
    end
    status_q    <= status_d;
    res_job_q   <= res_job_d;
    res_prio_q  <= res_prio_d;
    res_prog_q  <= res_prog_d;
    res_start_q <= res_start_d;
    last_q      <= last_d;
  end

  assign strobe_o         = strobe_q;
  assign status_o         = status_q;
  assign out_job_id_o     = res_job_q;
  assign out_priority_o   = res_prio_q;
  assign out_program_o    = res_prog_q;
  assign out_start_time_o = res_start_q;
  assign last_o           = last_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(Depth))
    else $error("fill count beyond capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.insert && !full) |=> (fill_q == $past(fill_q) + CntW'(1)))
    else $error("accepted insert did not grow the fill count");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (fill_q != '0))
    else $error("pop from an empty row");

  a_last_ends_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop && !stat_o.next_due) |=> !cmd_i.pop)
    else $error("pop continued after the last due job");
`endif

endmodule

@@ sv/release_time_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Release-time priority queue
// Holds pending jobs sorted by start time, then priority, then arrival, and
// releases every job due at a given elapsed time.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken at a clock edge with start high and
//   busy low. operation selects insert (job_id, start_time, priority_req,
//   program_req) or release (elapsed_time).
//   Result channel: each result is shown for one cycle with strobe_o high.
//   An insert gives one result, accepted or full, with last_o set. A release
//   gives one result per due job, head first, last_o on the final one, or no
//   result when nothing is due.
//   Timing: an insert holds busy for its insert step and its result appears
//   in the cycle after that step, so the next item is taken only once the
//   insert step is over. A release holds busy while it pops the due jobs,
//   one pop of the head slot per cycle, and each result follows its pop.
//   Every slot compares against the new job in parallel, so an insert is a
//   single compare-and-shift step regardless of the fill level.
//   Reset empties the queue; no clearing pass is needed. The receiver cannot
//   stall, so results are never held back.
// ----------------------------------------------------------------------------
module release_time_priority_queue #(
  parameter int unsigned DEPTH = rtpq_pkg::DepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        operation_i,
  input  logic [rtpq_pkg::JobW-1:0]   job_id_i,
  input  logic [rtpq_pkg::TimeW-1:0]  start_time_i,
  input  logic [rtpq_pkg::PrioW-1:0]  priority_req_i,
  input  logic [rtpq_pkg::ProgW-1:0]  program_req_i,
  input  logic [rtpq_pkg::TimeW-1:0]  elapsed_time_i,
  output logic                        strobe_o,
  output logic [rtpq_pkg::StatW-1:0]  status_o,
  output logic [rtpq_pkg::JobW-1:0]   out_job_id_o,
  output logic [rtpq_pkg::PrioW-1:0]  out_priority_o,
  output logic [rtpq_pkg::ProgW-1:0]  out_program_o,
  output logic [rtpq_pkg::TimeW-1:0]  out_start_time_o,
  output logic                        last_o
);

  rtpq_pkg::cmd_t  cmd;
  rtpq_pkg::stat_t stat;
  rtpq_pkg::op_e   op;

  assign op = rtpq_pkg::op_e'(operation_i);

  // Sequence the items
  rtpq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op),
    .stat_i (stat),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // Hold the sorted row and form results
  rtpq_dp #(
    .Depth (DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .job_id_i         (job_id_i),
    .start_time_i     (start_time_i),
    .priority_req_i   (priority_req_i),
    .program_req_i    (program_req_i),
    .elapsed_time_i   (elapsed_time_i),
    .strobe_o         (strobe_o),
    .status_o         (status_o),
    .out_job_id_o     (out_job_id_o),
    .out_priority_o   (out_priority_o),
    .out_program_o    (out_program_o),
    .out_start_time_o (out_start_time_o),
    .last_o           (last_o)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Release-time priority queue testbench
// Drives insert and release items through the command channel and checks
// every result strobe against a sorted job store kept in the testbench. A
// directed opening covers field extremes, ties, a full store, an empty
// release and two releases that empty it. Random items with slowly advancing
// times and bursts of inserts follow.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned Depth      = rtpq_pkg::DepthDefault;
  localparam int unsigned NumRandom  = 350;
  localparam int unsigned CycleLimit = 200000;

  // One command item, as driven on the ports
  typedef struct packed {
    rtpq_pkg::op_e                   op;
    logic [rtpq_pkg::JobW-1:0]       job;
    logic [rtpq_pkg::TimeW-1:0]      start_time;
    logic [rtpq_pkg::PrioW-1:0]      prio;
    logic [rtpq_pkg::ProgW-1:0]      prog;
    logic [rtpq_pkg::TimeW-1:0]      elapsed;
  } job_item_t;

  // One result, as seen on the strobe
  typedef struct packed {
    rtpq_pkg::status_e               status;
    logic [rtpq_pkg::JobW-1:0]       job;
    logic [rtpq_pkg::PrioW-1:0]      prio;
    logic [rtpq_pkg::ProgW-1:0]      prog;
    logic [rtpq_pkg::TimeW-1:0]      start_time;
    logic                            last;
  } job_result_t;

  // Sorted job store and the results it is still owed
  class rtpq_scoreboard;
    logic [rtpq_pkg::TimeW-1:0] slot_start [Depth];
    logic [rtpq_pkg::PrioW-1:0] slot_prio  [Depth];
    logic [rtpq_pkg::JobW-1:0]  slot_job   [Depth];
    logic [rtpq_pkg::ProgW-1:0] slot_prog  [Depth];
    int unsigned                fill;
    job_result_t                owed_q [$];
    int unsigned                n_errors;

    function new();
      fill     = 0;
      n_errors = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Apply an accepted item to the store and queue the results it causes
    function void note_item(job_item_t it);
      int unsigned pos;
      int unsigned due;
      int          i;
      job_result_t r;
      r.status     = rtpq_pkg::StAccepted;
      r.job        = '0;
      r.prio       = '0;
      r.prog       = '0;
      r.start_time = '0;
      r.last       = 1'b1;
      if (it.op == rtpq_pkg::OpInsert) begin
        if (fill >= Depth) begin
          r.status = rtpq_pkg::StFull;
        end else begin
          // place after every entry that sorts at or before the new job
          pos = 0;
          while (pos < fill && (slot_start[pos] < it.start_time ||
                 (slot_start[pos] == it.start_time && slot_prio[pos] <= it.prio)))
            pos++;
          for (i = fill; i > int'(pos); i--) begin
            slot_start[i] = slot_start[i-1];
            slot_prio[i]  = slot_prio[i-1];
            slot_job[i]   = slot_job[i-1];
            slot_prog[i]  = slot_prog[i-1];
          end
          slot_start[pos] = it.start_time;
          slot_prio[pos]  = it.prio;
          slot_job[pos]   = it.job;
          slot_prog[pos]  = it.prog;
          fill++;
        end
        owed_q.push_back(r);
      end else begin
        // due jobs form the front of the store
        due = 0;
        while (due < fill && slot_start[due] <= it.elapsed)
          due++;
        for (i = 0; i < int'(due); i++) begin
          r.status     = rtpq_pkg::StReleased;
          r.job        = slot_job[i];
          r.prio       = slot_prio[i];
          r.prog       = slot_prog[i];
          r.start_time = slot_start[i];
          r.last       = (i + 1 == int'(due));
          owed_q.push_back(r);
        end
        for (i = due; i < int'(fill); i++) begin
          slot_start[i-due] = slot_start[i];
          slot_prio[i-due]  = slot_prio[i];
          slot_job[i-due]   = slot_job[i];
          slot_prog[i-due]  = slot_prog[i];
        end
        fill -= due;
      end
    endfunction

    function void report(string what, job_result_t want, job_result_t got);
      n_errors++;
      if (n_errors <= 10)
        $display({"%0t %s: exp st=%0d job=%h pri=%h prog=%0d start=%h last=%b",
                  " | got st=%0d job=%h pri=%h prog=%0d start=%h last=%b"},
                 $realtime, what, want.status, want.job, want.prio, want.prog,
                 want.start_time, want.last, got.status, got.job, got.prio,
                 got.prog, got.start_time, got.last);
    endfunction

    // Compare a strobed result with the oldest owed one
    function void check_result(job_result_t got);
      job_result_t want;
      if (owed_q.size() == 0) begin
        report("unexpected result", got, got);
        return;
      end
      want = owed_q.pop_front();
      if (got != want)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic                        operation_i;
  logic [rtpq_pkg::JobW-1:0]   job_id_i;
  logic [rtpq_pkg::TimeW-1:0]  start_time_i;
  logic [rtpq_pkg::PrioW-1:0]  priority_req_i;
  logic [rtpq_pkg::ProgW-1:0]  program_req_i;
  logic [rtpq_pkg::TimeW-1:0]  elapsed_time_i;
  logic                        strobe_o;
  logic [rtpq_pkg::StatW-1:0]  status_o;
  logic [rtpq_pkg::JobW-1:0]   out_job_id_o;
  logic [rtpq_pkg::PrioW-1:0]  out_priority_o;
  logic [rtpq_pkg::ProgW-1:0]  out_program_o;
  logic [rtpq_pkg::TimeW-1:0]  out_start_time_o;
  logic                        last_o;

  rtpq_scoreboard board;
  int unsigned    cycles;

  release_time_priority_queue #(.DEPTH(Depth)) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .job_id_i         (job_id_i),
    .start_time_i     (start_time_i),
    .priority_req_i   (priority_req_i),
    .program_req_i    (program_req_i),
    .elapsed_time_i   (elapsed_time_i),
    .strobe_o         (strobe_o),
    .status_o         (status_o),
    .out_job_id_o     (out_job_id_o),
    .out_priority_o   (out_priority_o),
    .out_program_o    (out_program_o),
    .out_start_time_o (out_start_time_o),
    .last_o           (last_o)
  );

  // Toggle the clock every half period
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Check every strobed result
  always @(posedge clk_i) begin
    job_result_t got;
    if (rst_ni && strobe_o) begin
      got.status     = rtpq_pkg::status_e'(status_o);
      got.job        = out_job_id_o;
      got.prio       = out_priority_o;
      got.prog       = out_program_o;
      got.start_time = out_start_time_o;
      got.last       = last_o;
      board.check_result(got);
    end
  end

  // Hold the item on the ports until taken, idling first at random
  task automatic send_item(input job_item_t it, input bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 31) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    operation_i    <= it.op;
    job_id_i       <= it.job;
    start_time_i   <= it.start_time;
    priority_req_i <= it.prio;
    program_req_i  <= it.prog;
    elapsed_time_i <= it.elapsed;
    do @(posedge clk_i); while (busy);
    board.note_item(it);
  endtask

  function automatic job_item_t release_at(logic [rtpq_pkg::TimeW-1:0] now);
    job_item_t it;
    it.op         = rtpq_pkg::OpRelease;
    it.job        = 16'($urandom);
    it.start_time = 16'($urandom);
    it.prio       = 4'($urandom);
    it.prog       = 2'($urandom);
    it.elapsed    = now;
    return it;
  endfunction

  initial begin
    job_item_t it;
    int        base;
    int        ins_pct;
    int        k;

    board          = new();
    rst_ni         = 1'b0;
    start          = 1'b0;
    operation_i    = 1'b0;
    job_id_i       = '0;
    start_time_i   = '0;
    priority_req_i = '0;
    program_req_i  = '0;
    elapsed_time_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // release on an empty store, then one job with nothing yet due
    send_item(release_at(16'd0), 1'b1);
    it.op = rtpq_pkg::OpInsert; it.job = 16'h1234; it.start_time = 16'd100;
    it.prio = 4'd5; it.prog = 2'd1; it.elapsed = 16'hFFFF;
    send_item(it, 1'b1);
    send_item(release_at(16'd99), 1'b1);

    // fill the store with extremes and ties on start time and priority
    for (k = 0; k < 15; k++) begin
      it.op         = rtpq_pkg::OpInsert;
      it.start_time = (k % 3 == 0) ? 16'd0 : (k % 3 == 1) ? 16'd100 : 16'hFFFF;
      it.prio       = (k % 4 == 0) ? 4'd0 : (k % 4 == 1) ? 4'd15 : 4'd5;
      it.job        = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'(k * 16'h1111);
      it.prog       = 2'(k % 4);
      it.elapsed    = 16'($urandom);
      send_item(it, 1'b1);
    end

    // refuse an insert into the full store
    it.start_time = 16'd0; it.job = 16'hA5A5;
    send_item(it, 1'b1);

    // release all but the latest jobs, then the rest
    send_item(release_at(16'hFFFE), 1'b1);
    send_item(release_at(16'hFFFF), 1'b1);

    // random items around a slowly advancing time, in insert-heavy phases
    base    = 0;
    ins_pct = 65;
    for (k = 0; k < NumRandom; k++) begin
      if (k % 50 == 0)
        ins_pct = ($urandom_range(0, 2) == 0) ? 45 : ($urandom_range(0, 1) ? 65 : 85);
      if ($urandom_range(0, 99) < ins_pct) begin
        it.op         = rtpq_pkg::OpInsert;
        it.job        = 16'($urandom);
        it.prio       = $urandom_range(0, 1) ? 4'($urandom) : 4'($urandom_range(0, 2));
        it.prog       = 2'($urandom_range(0, 3));
        it.elapsed    = 16'($urandom);
        it.start_time = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                    : 16'(base + $urandom_range(0, 60));
      end else begin
        it = release_at(($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                    : 16'(base + $urandom_range(0, 40)));
        base += $urandom_range(0, 12);
        if (base > 65400)
          base = 0;
      end
      // keep a long stretch free of gaps
      send_item(it, !(k >= 120 && k < 200));
    end
    start <= 1'b0;

    // drain the owed results, then let the block settle
    while (board.pending() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (board.n_errors == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/rtpq_pkg.sv
sv/rtpq_ctrl.sv
sv/rtpq_dp.sv
sv/release_time_priority_queue.sv
test/tb_top.sv
